// File: rtl/rau_pkg.sv
// Package for the rational arithmetic unit: opcodes, status codes, sequencer states.
// No dependencies.
package rau_pkg;

	localparam int unsigned WIDTH_DEFAULT = 32;

	typedef enum logic [2:0] {
		OP_ADD    = 3'd0,
		OP_SUB    = 3'd1,
		OP_MUL    = 3'd2,
		OP_DIV    = 3'd3,
		OP_NEG    = 3'd4,
		OP_INV    = 3'd5,
		OP_REDUCE = 3'd6,
		OP_RSVD   = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_COMB,
		S_GSHIFT,
		S_GU,
		S_GV,
		S_GSUB,
		S_DIVN,
		S_DIVD,
		S_FIN,
		S_OUT
	} state_t;

	// Control from the sequencer to the datapath.
	typedef struct packed {
		logic load;
		logic step;
	} ctl_t;

endpackage

// File: rtl/rau_if.sv
// Valid/ready channel interface with a generic payload.
// Depends on nothing.
interface rau_if #(parameter int unsigned PW = 8);
	logic          valid;
	logic          ready;
	logic [PW-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/rau_mul.sv
// Sequential unsigned multiplier, one bit of the multiplier a cycle.
// Depends on nothing.
module rau_mul #(
	parameter int unsigned W = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic [2*W-1:0] p,
	output logic           done
);
	localparam int unsigned CW = $clog2(W + 1);
	logic [2*W-1:0] acc_q;
	logic [2*W-1:0] mc_q;
	logic [W-1:0]   mp_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;

	// Shift-add: one partial product per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mc_q  <= {{W{1'b0}}, a};
			mp_q  <= b;
		end else if (busy_q) begin
			if (mp_q[0]) acc_q <= acc_q + mc_q;
			mc_q <= mc_q << 1;
			mp_q <= mp_q >> 1;
		end
	end

	assign p    = acc_q;
	assign done = !busy_q;
endmodule

// File: rtl/rau_datapath.sv
// Datapath: cross products, binary GCD and exact restoring division on 2W+1-bit values.
// Depends on rau_pkg and rau_mul.
module rau_datapath #(
	parameter int unsigned W = rau_pkg::WIDTH_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rau_pkg::state_t st,
	input  logic           enter,
	input  logic [2:0]     op_in,
	input  logic [W-1:0]   an_in,
	input  logic [W-1:0]   ad_in,
	input  logic [W-1:0]   bn_in,
	input  logic [W-1:0]   bd_in,
	output logic           bad,
	output logic           unary,
	output logic           mul_done,
	output logic           gsh_done,
	output logic           u_zero,
	output logic           u_even,
	output logic           v_even,
	output logic           v_zero,
	output logic           div_last,
	output logic           kz,
	output logic [W-1:0]   res_num,
	output logic [W-2:0]   res_den,
	output logic [1:0]     status
);
	localparam int unsigned XW = 2 * W + 1;
	localparam int unsigned KW = $clog2(XW + 1);
	localparam int unsigned DW = $clog2(XW + 1);

	logic [2:0]    op_q;
	logic [W-1:0]  anm_q, adm_q, bnm_q, bdm_q;
	logic          ans_q, ads_q, bns_q, bds_q;
	logic [XW-1:0] p1_q, p2_q;
	logic          s1_q, s2_q;
	logic [XW-1:0] d_q, u_q, v_q;
	logic          nneg_q, dneg_q;
	logic [KW-1:0] k_q;
	logic [XW-1:0] g_q;
	logic [XW-1:0] dvd_q, rem_q, quo_q, rn_q;
	logic [DW-1:0] dc_q;
	logic [W-1:0]  resn_q;
	logic [W-2:0]  resd_q;
	logic [1:0]    stat_q;

	// Magnitudes of the incoming fields.
	function automatic logic [W-1:0] mag(input logic [W-1:0] x);
		mag = x[W-1] ? (~x + 1'b1) : x;
	endfunction

	// Shared multiplier, used for three products in turn.
	logic          m_start;
	logic [W-1:0]  m_a, m_b;
	logic [2*W-1:0] m_p;
	logic          m_done;
	rau_mul #(.W(W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(m_start), .a(m_a), .b(m_b),
		.p(m_p), .done(m_done)
	);

	always_comb begin
		m_start = enter;
		m_a = mag(an_in);
		m_b = mag(bd_in);
		case (st)
			rau_pkg::S_MUL1: begin
				m_start = m_done;
				m_a = (op_q == rau_pkg::OP_MUL) ? anm_q : bnm_q;
				m_b = (op_q == rau_pkg::OP_MUL) ? bnm_q : adm_q;
			end
			rau_pkg::S_MUL2: begin
				m_start = m_done;
				m_a = adm_q;
				m_b = (op_q == rau_pkg::OP_DIV) ? bnm_q : bdm_q;
			end
			default: begin
				m_start = enter;
				if (op_in == rau_pkg::OP_MUL) m_b = mag(bn_in);
			end
		endcase
	end
	assign mul_done = m_done;

	assign unary = op_q[2];
	assign bad = (adm_q == '0) ||
		(!op_q[2] && bdm_q == '0) ||
		(op_q == rau_pkg::OP_DIV && bnm_q == '0) ||
		(op_q == rau_pkg::OP_INV && anm_q == '0);

	// Signed combine of the two numerator products.
	logic [XW-1:0] sum_mag;
	logic          sum_neg;
	always_comb begin
		if (s1_q == s2_q) begin
			sum_mag = p1_q + p2_q;
			sum_neg = s1_q;
		end else if (p1_q >= p2_q) begin
			sum_mag = p1_q - p2_q;
			sum_neg = s1_q;
		end else begin
			sum_mag = p2_q - p1_q;
			sum_neg = s2_q;
		end
	end

	// Raw numerator and denominator for the operation.
	logic [XW-1:0] n_c, d_c;
	logic          nneg_c, dneg_c;
	always_comb begin
		n_c = XW'(anm_q);
		nneg_c = ans_q;
		d_c = XW'(adm_q);
		dneg_c = ads_q;
		case (op_q)
			rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
				n_c = sum_mag; nneg_c = sum_neg; d_c = d_q; dneg_c = dneg_q;
			end
			rau_pkg::OP_MUL, rau_pkg::OP_DIV: begin
				n_c = p1_q; nneg_c = s1_q; d_c = d_q; dneg_c = dneg_q;
			end
			rau_pkg::OP_NEG: nneg_c = !ans_q;
			rau_pkg::OP_INV: begin
				n_c = XW'(adm_q); nneg_c = ads_q; d_c = XW'(anm_q); dneg_c = ans_q;
			end
			default: ;
		endcase
	end

	assign u_zero   = (u_q == '0);
	assign u_even   = !u_q[0];
	assign v_even   = !v_q[0];
	assign v_zero   = (v_q == '0);
	assign gsh_done = u_q[0] | v_q[0];
	assign kz       = (k_q == '0);
	assign div_last = (dc_q == DW'(1));

	logic [XW:0] trial;
	assign trial = {rem_q, dvd_q[XW-1]} - {1'b0, g_q};

	logic          neg_res;
	logic [XW-1:0] half;
	assign neg_res = (rn_q != '0) && (nneg_q != dneg_q);
	assign half = XW'(1) << (W - 1);

	always_ff @(posedge clk) begin
		case (st)
			rau_pkg::S_IDLE: if (enter) begin
				op_q <= op_in;
				anm_q <= mag(an_in); ans_q <= an_in[W-1];
				adm_q <= mag(ad_in); ads_q <= ad_in[W-1];
				bnm_q <= mag(bn_in); bns_q <= bn_in[W-1];
				bdm_q <= mag(bd_in); bds_q <= bd_in[W-1];
			end
			rau_pkg::S_MUL1: begin
				if (bad) begin
					stat_q <= rau_pkg::ST_ZERO_DEN; resn_q <= '0; resd_q <= (W-1)'(1);
				end else if (m_done) begin
					p1_q <= {1'b0, m_p};
					s1_q <= (op_q == rau_pkg::OP_MUL || op_q == rau_pkg::OP_DIV) ?
						(ans_q ^ ((op_q == rau_pkg::OP_MUL) ? bns_q : bds_q)) :
						(ans_q ^ bds_q);
				end
			end
			rau_pkg::S_MUL2: if (m_done) begin
				p2_q <= {1'b0, m_p};
				s2_q <= bns_q ^ ads_q ^ (op_q == rau_pkg::OP_SUB);
			end
			rau_pkg::S_MUL3: if (m_done) begin
				d_q <= {1'b0, m_p};
				dneg_q <= ads_q ^ ((op_q == rau_pkg::OP_DIV) ? bns_q : bds_q);
			end
			// Latch the raw fraction and seed the GCD and the first division.
			rau_pkg::S_COMB: begin
				nneg_q <= nneg_c;
				d_q <= d_c; dneg_q <= dneg_c;
				u_q <= n_c; v_q <= d_c;
				k_q <= '0;
				dvd_q <= n_c; rem_q <= '0; quo_q <= '0; dc_q <= DW'(XW);
			end
			rau_pkg::S_GSHIFT: begin
				if (u_zero) begin
					u_q <= v_q;
					v_q <= '0;
				end else if (!gsh_done) begin
					u_q <= u_q >> 1; v_q <= v_q >> 1; k_q <= k_q + 1'b1;
				end
			end
			rau_pkg::S_GU: if (u_even) u_q <= u_q >> 1;
			rau_pkg::S_GV: if (v_even && !v_zero) v_q <= v_q >> 1;
			rau_pkg::S_GSUB: begin
				if (u_q > v_q) begin
					u_q <= v_q; v_q <= u_q - v_q;
				end else begin
					v_q <= v_q - u_q;
				end
			end
			rau_pkg::S_DIVN, rau_pkg::S_DIVD: begin
				if (!kz) begin
					u_q <= u_q << 1; k_q <= k_q - 1'b1;
				end else if (div_last && st == rau_pkg::S_DIVN) begin
					rn_q <= trial[XW] ? {quo_q[XW-2:0], 1'b0} :
						{quo_q[XW-2:0], 1'b1};
					dvd_q <= d_q; rem_q <= '0; quo_q <= '0;
					dc_q <= DW'(XW);
				end else begin
					dc_q <= dc_q - 1'b1;
					dvd_q <= dvd_q << 1;
					if (!trial[XW]) begin
						rem_q <= trial[XW-1:0];
						quo_q <= {quo_q[XW-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[XW-2:0], dvd_q[XW-1]};
						quo_q <= {quo_q[XW-2:0], 1'b0};
					end
				end
			end
			rau_pkg::S_FIN: begin
				if (quo_q > half - 1'b1 || rn_q > (neg_res ? half : half - 1'b1)) begin
					resn_q <= '0; resd_q <= (W-1)'(1); stat_q <= rau_pkg::ST_OVERFLOW;
				end else begin
					resn_q <= neg_res ? W'(~rn_q + 1'b1) : rn_q[W-1:0];
					resd_q <= quo_q[W-2:0];
					stat_q <= rau_pkg::ST_OK;
				end
			end
			default: ;
		endcase
	end

	always_comb g_q = u_q;

	assign res_num = resn_q;
	assign res_den = resd_q;
	assign status  = stat_q;
endmodule

// File: rtl/rational_arithmetic_unit_core.sv
// Channel      Dir  Payload
// req          in   {req_type, a_num, a_den, b_num, b_den}
// rsp          out  {res_num, res_den, status}
//
// Invalid operands (zero denominator, divide by zero) pass from the first product
// state straight to the result state. Otherwise binary operations compute three
// products on the shared multiplier, then combine them, run a binary GCD of shifts
// and subtracts, restore the common factors of two, run two restoring divisions and
// a range check, and present the result; unary operations skip the products.
// Reset is asynchronous, active low, and clears the sequencer and the multiplier's control only.
// req.ready is high only in the idle state; a held result waits for rsp.ready.
module rational_arithmetic_unit_core #(
	parameter int unsigned WIDTH = rau_pkg::WIDTH_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	rau_if.sink   req,
	rau_if.source rsp
);
	rau_pkg::state_t st_q, st_d;
	logic enter;
	logic bad, unary, mul_done, gsh_done, u_zero, u_even, v_even, v_zero, div_last, kz;
	logic [WIDTH-1:0] res_num;
	logic [WIDTH-2:0] res_den;
	logic [1:0] status;
	logic [3*WIDTH-1:0] rsp_unused;

	assign enter = req.valid && req.ready;
	assign rsp_unused = '0;

	rau_datapath #(.W(WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .st(st_q), .enter(enter),
		.op_in(req.data[4*WIDTH +: 3]),
		.an_in(req.data[3*WIDTH +: WIDTH]), .ad_in(req.data[2*WIDTH +: WIDTH]),
		.bn_in(req.data[WIDTH +: WIDTH]), .bd_in(req.data[0 +: WIDTH]),
		.bad(bad), .unary(unary), .mul_done(mul_done), .gsh_done(gsh_done),
		.u_zero(u_zero), .u_even(u_even), .v_even(v_even), .v_zero(v_zero),
		.div_last(div_last), .kz(kz), .res_num(res_num), .res_den(res_den),
		.status(status)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= rau_pkg::S_IDLE;
		else st_q <= st_d;
	end

	// Next state.
	always_comb begin
		st_d = st_q;
		case (st_q)
			rau_pkg::S_IDLE:   if (enter) st_d = rau_pkg::S_MUL1;
			rau_pkg::S_MUL1:   if (bad) st_d = rau_pkg::S_OUT;
				else if (unary) st_d = rau_pkg::S_COMB;
				else if (mul_done) st_d = rau_pkg::S_MUL2;
			rau_pkg::S_MUL2:   if (mul_done) st_d = rau_pkg::S_MUL3;
			rau_pkg::S_MUL3:   if (mul_done) st_d = rau_pkg::S_COMB;
			rau_pkg::S_COMB:   st_d = rau_pkg::S_GSHIFT;
			rau_pkg::S_GSHIFT: if (u_zero) st_d = rau_pkg::S_DIVN;
				else if (gsh_done) st_d = rau_pkg::S_GU;
			rau_pkg::S_GU:     if (!u_even) st_d = rau_pkg::S_GV;
			rau_pkg::S_GV:     if (v_zero) st_d = rau_pkg::S_DIVN;
				else if (!v_even) st_d = rau_pkg::S_GSUB;
			rau_pkg::S_GSUB:   st_d = rau_pkg::S_GV;
			rau_pkg::S_DIVN:   if (kz && div_last) st_d = rau_pkg::S_DIVD;
			rau_pkg::S_DIVD:   if (div_last) st_d = rau_pkg::S_FIN;
			rau_pkg::S_FIN:    st_d = rau_pkg::S_OUT;
			rau_pkg::S_OUT:    if (rsp.ready) st_d = rau_pkg::S_IDLE;
			default:           st_d = rau_pkg::S_IDLE;
		endcase
	end

	assign req.ready = (st_q == rau_pkg::S_IDLE);
	assign rsp.valid = (st_q == rau_pkg::S_OUT);
	assign rsp.data  = {res_num, res_den, status} | rsp_unused[2*WIDTH:0];
endmodule

// File: rtl/rau_checker.sv
// Port-level checker for the rational arithmetic unit, bound to the top level.
// Depends on rau_pkg and rational_arithmetic_unit_core.
module rau_checker #(
	parameter int unsigned WIDTH = rau_pkg::WIDTH_DEFAULT
) (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [2*WIDTH:0] rsp_data
);
	// No new request while a result is pending.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid)) else $error("ready while result held");
	// A request transaction is followed by a busy cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready) else $error("not busy");
	// The denominator is never zero.
	a_den: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data[WIDTH:2] != '0)) else $error("zero den");
	// An error status carries 0/1; the check covers the zero numerator.
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data[1:0] != rau_pkg::ST_OK) |->
		(rsp_data[2*WIDTH:WIDTH+1] == '0)) else $error("bad error value");
	// A stalled result stays valid and unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
		else $error("result changed while stalled");
endmodule

bind rational_arithmetic_unit_core rau_checker #(.WIDTH(WIDTH)) u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
